// ===== sv/dqu_pkg.sv =====
// Double-ended queue unit: shared types and constants.
// Used by the channel interfaces and the top level; depends on nothing.
package dqu_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 7;

    // Operation class, taken from the upper two command bits.
    // The lowest command bit selects the tail end.
    typedef enum logic [1:0] {
        OP_PUT = 2'd0,
        OP_GET = 2'd1,
        OP_ITH = 2'd2,
        OP_REM = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SEARCH,
        S_SHIFT,
        S_RESP
    } state_t;

endpackage

// ===== sv/dqu_req_if.sv =====
// Command channel of the double-ended queue unit (valid/ready).
// Depends on dqu_pkg for field widths.
interface dqu_req_if
    import dqu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

// ===== sv/dqu_rsp_if.sv =====
// Result channel of the double-ended queue unit (valid/ready).
// Depends on dqu_pkg for field widths.
interface dqu_rsp_if
    import dqu_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;

    modport source (output valid, output result_value, output status, output length,
                    input ready);
    modport sink   (input valid, input result_value, input status, input length,
                    output ready);
endinterface

// ===== sv/dqu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dqu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/double_ended_queue_unit.sv =====
// Double-ended queue unit, top level. Depends on dqu_pkg, dqu_req_if, dqu_rsp_if, dqu_ram.
//
// A bounded deque of DEPTH words held as a ring in one RAM (registered read, one write
// and one read port per cycle). Each command item gives exactly one result item carrying
// the word, a status and the length after the command. The unit works on one item at a
// time and drops req.ready until that item's result has been loaded into the output
// register; the result then waits there while the next command is taken. Steps from
// acceptance: put, and any command that S_EXEC ends with an error status, go from S_EXEC
// straight to S_RESP; get and ith pass through S_RDWAIT for one RAM read; rem runs
// S_SEARCH, comparing words one per cycle through the single comparator until the first
// match or the whole length, then, if words lie behind the removed one, S_SHIFT, moving
// them one place per cycle to close the gap. Words narrower than 32 bits keep the low
// DATA_WIDTH bits of value; the store needs no clearing after reset, since only written
// entries are ever read.
module double_ended_queue_unit
    import dqu_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    dqu_req_if.sink   req,
    dqu_rsp_if.source rsp
);
    localparam int AW = $clog2(DEPTH);       // ring address
    localparam int CW = $clog2(DEPTH + 1);   // count, 0..DEPTH
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // Ring helpers
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                                input logic [CW-1:0] i);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(i);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Control state
    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    // Latched command
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    // Search / compaction bookkeeping
    logic [CW-1:0] idx_reg, idx_next;     // logical index of the word being compared
    logic [CW-1:0] k_reg, k_next;         // words compared so far
    logic [CW-1:0] mv_reg, mv_next;       // words still to move down
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;

    // Pending result and output register
    logic [VALUE_W-1:0] res_val_reg, res_val_next;
    status_t            res_st_reg, res_st_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;

    // RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Shared slot adder: ring address of a logical index from the head
    logic [CW-1:0] slot_idx;
    logic [AW-1:0] slot_addr;

    op_t           op;
    logic          tail;
    logic [CW-1:0] mv_calc;

    assign op        = op_t'(cmd_reg[CMD_W-1:1]);
    assign tail      = cmd_reg[0];
    assign slot_addr = ring_slot(head_reg, slot_idx);
    assign mv_calc   = count_reg - CW'(1) - idx_reg;

    dqu_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        mv_next         = mv_reg;
        rd_addr_next    = rd_addr_reg;
        wr_addr_next    = wr_addr_reg;
        res_val_next    = res_val_reg;
        res_st_next     = res_st_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_addr_reg;
        ram_wdata       = val_reg;
        ram_raddr       = rd_addr_reg;
        slot_idx        = '0;
        req.ready       = 1'b0;

        // Output register drains independently of the sequencer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    val_next   = DATA_WIDTH'(req.value);
                    pos_next   = req.position;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_val_next = '0;
                res_st_next  = ST_OK;
                state_next   = S_RESP;
                case (op)
                    OP_PUT:
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_st_next = ST_FULL;
                        end
                        else if (tail)
                        begin
                            slot_idx   = count_reg;
                            ram_we     = 1'b1;
                            ram_waddr  = slot_addr;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = ring_dec(head_reg);
                            head_next  = ring_dec(head_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end

                    OP_GET:
                    begin
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                        end
                        else
                        begin
                            slot_idx   = tail ? count_reg - CW'(1) : '0;
                            ram_raddr  = slot_addr;
                            state_next = S_RDWAIT;
                        end
                    end

                    OP_ITH:
                    begin
                        if (XW'(pos_reg) >= XW'(count_reg))
                        begin
                            res_st_next = ST_RANGE;
                        end
                        else
                        begin
                            slot_idx   = tail ? count_reg - CW'(1) - CW'(pos_reg)
                                              : CW'(pos_reg);
                            ram_raddr  = slot_addr;
                            state_next = S_RDWAIT;
                        end
                    end

                    OP_REM:
                    begin
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            // first word to compare: nearest the chosen end
                            slot_idx     = tail ? count_reg - CW'(1) : '0;
                            ram_raddr    = slot_addr;
                            rd_addr_next = slot_addr;
                            idx_next     = slot_idx;
                            k_next       = '0;
                            state_next   = S_SEARCH;
                        end
                    end

                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_RDWAIT:
            begin
                res_val_next = VALUE_W'(ram_rdata);
                if (op == OP_GET)
                begin
                    count_next = count_reg - CW'(1);
                    if (!tail)
                    begin
                        head_next = ring_inc(head_reg);
                    end
                end
                state_next = S_RESP;
            end

            S_SEARCH:
            begin
                // ram_rdata holds the word at rd_addr_reg
                if (ram_rdata == val_reg)
                begin
                    res_val_next = VALUE_W'(ram_rdata);
                    if (mv_calc != '0)
                    begin
                        ram_raddr    = ring_inc(rd_addr_reg);
                        rd_addr_next = ring_inc(rd_addr_reg);
                        wr_addr_next = rd_addr_reg;
                        mv_next      = mv_calc;
                        state_next   = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESP;
                    end
                end
                else if (k_reg + CW'(1) < count_reg)
                begin
                    ram_raddr    = tail ? ring_dec(rd_addr_reg) : ring_inc(rd_addr_reg);
                    rd_addr_next = ram_raddr;
                    idx_next     = tail ? idx_reg - CW'(1) : idx_reg + CW'(1);
                    k_next       = k_reg + CW'(1);
                end
                else
                begin
                    res_st_next = ST_NOTFOUND;
                    state_next  = S_RESP;
                end
            end

            S_SHIFT:
            begin
                // move the word read last cycle one place towards the head
                ram_we       = 1'b1;
                ram_waddr    = wr_addr_reg;
                ram_wdata    = ram_rdata;
                wr_addr_next = rd_addr_reg;
                if (mv_reg > CW'(1))
                begin
                    ram_raddr    = ring_inc(rd_addr_reg);
                    rd_addr_next = ring_inc(rd_addr_reg);
                    mv_next      = mv_reg - CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_val_reg;
                    out_status_next = res_st_reg;
                    out_len_next    = LEN_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        mv_reg         <= mv_next;
        rd_addr_reg    <= rd_addr_next;
        wr_addr_reg    <= wr_addr_next;
        res_val_reg    <= res_val_next;
        res_st_reg     <= res_st_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.length       = out_len_reg;
endmodule
